/* rtl/palette_fade_engine_top_macros.svh */
`ifndef PALETTE_FADE_ENGINE_TOP_MACROS_SVH
`define PALETTE_FADE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 768;
	localparam int unsigned COLOR_BITS_DEF      = 6;

	localparam int unsigned KIND_W  = 3;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned VAL_W   = 6;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned TICK_W  = 20;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WR_CUR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WR_TGT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RD_CUR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_START  = 3'd4;

	// register indexes
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_STEP = 1'b1;

	// interval = (step / STEP_DIV) * SLOW_UNIT for step >= STEP_DIV
	localparam int unsigned SLOW_UNIT = 10000;
	localparam int unsigned STEP_DIV  = 4;
	localparam int unsigned STEP_SH   = 2;
	localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(4);
	localparam logic [TICK_W-1:0] INTERVAL_RST = TICK_W'((4 / STEP_DIV) * SLOW_UNIT);

	typedef struct packed {
		logic              fade_in_mode;
		logic [TICK_W-1:0] interval;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/pfe_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pfe_in_if;
	import pfe_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  entry_index;
	logic [VAL_W-1:0]  entry_value;

	modport source (output valid, kind, entry_index, entry_value, input ready);
	modport sink   (input valid, kind, entry_index, entry_value, output ready);
endinterface

interface pfe_out_if;
	import pfe_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] read_value;
	logic             palette_updated;
	logic             fade_done;

	modport source (output valid, read_value, palette_updated, fade_done, input ready);
	modport sink   (input valid, read_value, palette_updated, fade_done, output ready);
endinterface

`default_nettype wire

/* rtl/palette_fade_engine_top.sv */
// Results: entry write, idle or non-sweeping tick and fade-out start answer straight from IDLE; entry read
//   passes through READ; fade-in start runs a zeroing pass first; a sweeping tick answers after the sweep.
// Sweep length is set by the current-palette RAM: one read and one write-back per cycle.
// Throughput: one transaction in flight; the next is taken once its result is taken.
// Reset (arst_n low, async): idle, done set, tick phase 0, mode fade-out, step 4.
//   Palette RAMs are not cleared; entries are defined once written.
`timescale 1ns / 1ps
`default_nettype none

module palette_fade_engine_top #(
	parameter int unsigned PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF,
	parameter int unsigned COLOR_BITS      = pfe_pkg::COLOR_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	pfe_in_if.sink                          req,
	pfe_out_if.source                       rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pfe_pkg::APB_AW-1:0] paddr,
	input  wire logic [pfe_pkg::APB_DW-1:0] pwdata,
	output logic      [pfe_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import pfe_pkg::*;

	localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

	cfg_t                  cfg;

	// current palette: host writes, zeroing pass, sweep write-back
	logic                  cur_we;
	logic [ADDR_W-1:0]     cur_waddr;
	logic [COLOR_BITS-1:0] cur_wdata;
	logic [ADDR_W-1:0]     cur_raddr;
	logic [COLOR_BITS-1:0] cur_rdata;

	// target palette: host writes, read alongside the sweep
	logic                  tgt_we;
	logic [ADDR_W-1:0]     tgt_waddr;
	logic [COLOR_BITS-1:0] tgt_wdata;
	logic [ADDR_W-1:0]     tgt_raddr;
	logic [COLOR_BITS-1:0] tgt_rdata;

	// mode and step registers; tick interval is precomputed on the step write
	pfe_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfe_ram #(
		.WIDTH (COLOR_BITS),
		.DEPTH (PALETTE_ENTRIES)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	pfe_ram #(
		.WIDTH (COLOR_BITS),
		.DEPTH (PALETTE_ENTRIES)
	) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_waddr),
		.wdata (tgt_wdata),
		.raddr (tgt_raddr),
		.rdata (tgt_rdata)
	);

	// transaction decode, tick phase, sweep read/modify/write pipeline, result register
	pfe_seq #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES),
		.COLOR_BITS      (COLOR_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.cur_we    (cur_we),
		.cur_waddr (cur_waddr),
		.cur_wdata (cur_wdata),
		.cur_raddr (cur_raddr),
		.cur_rdata (cur_rdata),
		.tgt_we    (tgt_we),
		.tgt_waddr (tgt_waddr),
		.tgt_wdata (tgt_wdata),
		.tgt_raddr (tgt_raddr),
		.tgt_rdata (tgt_rdata)
	);
endmodule

`default_nettype wire

/* rtl/pfe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfe_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

/* rtl/pfe_apb.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfe_apb (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pfe_pkg::APB_AW-1:0]  paddr,
	input  wire logic [pfe_pkg::APB_DW-1:0]  pwdata,
	output logic      [pfe_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output pfe_pkg::cfg_t                    cfg
);
	import pfe_pkg::*;

	logic              mode_q;
	logic [STEP_W-1:0] step_q;
	logic [TICK_W-1:0] interval_q;
	logic              wr;
	logic              reg_idx;
	logic [STEP_W-1:0] step_w;
	logic [TICK_W-1:0] interval_w;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[STEP_SH];
	assign step_w  = pwdata[STEP_W-1:0];

	// interval derived once per write
	always_comb begin
		if (step_w >= STEP_W'(STEP_DIV)) begin
			interval_w = TICK_W'(step_w >> STEP_SH) * TICK_W'(SLOW_UNIT);
		end else if (step_w == '0) begin
			interval_w = TICK_W'(1);
		end else begin
			interval_w = TICK_W'(step_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			step_q     <= STEP_RST;
			interval_q <= INTERVAL_RST;
		end else if (wr) begin
			unique case (reg_idx)
				REG_MODE: mode_q <= pwdata[0];
				REG_STEP: begin
					step_q     <= step_w;
					interval_q <= interval_w;
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE: prdata = APB_DW'(mode_q);
			REG_STEP: prdata = APB_DW'(step_q);
		endcase
	end

	assign cfg.fade_in_mode = mode_q;
	assign cfg.interval     = interval_q;
endmodule

`default_nettype wire

/* rtl/pfe_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "palette_fade_engine_top_macros.svh"

module pfe_seq #(
	parameter int unsigned PALETTE_ENTRIES = 768,
	parameter int unsigned COLOR_BITS      = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	pfe_in_if.sink                                  req,
	pfe_out_if.source                               rsp,
	input  pfe_pkg::cfg_t                           cfg,
	output logic                                    cur_we,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]      cur_waddr,
	output logic [COLOR_BITS-1:0]                   cur_wdata,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]      cur_raddr,
	input  wire logic [COLOR_BITS-1:0]              cur_rdata,
	output logic                                    tgt_we,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]      tgt_waddr,
	output logic [COLOR_BITS-1:0]                   tgt_wdata,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]      tgt_raddr,
	input  wire logic [COLOR_BITS-1:0]              tgt_rdata
);
	import pfe_pkg::*;

	localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);
	localparam int unsigned CNT_W  = $clog2(PALETTE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(PALETTE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_CLEAR = 2'd2;
	localparam logic [1:0] ST_SWEEP = 2'd3;

	logic [1:0]            state_q, state_d;
	logic                  rsp_v_q;
	logic [VAL_W-1:0]      rv_q;
	logic                  upd_q;
	logic                  done_out_q;
	logic                  done_q, done_d;
	logic [TICK_W-1:0]     tick_q, tick_d;
	logic [TICK_W-1:0]     tick_inc;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  valid_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  changed_q, changed_d;
	logic                  range_q;

	logic                  acc;
	logic                  in_range;
	logic [ADDR_W-1:0]     idx_a;
	logic [COLOR_BITS-1:0] val_c;
	logic [ADDR_W-1:0]     cnt_a;
	logic                  reading;
	logic                  entry_chg;
	logic [COLOR_BITS-1:0] entry_new;

	logic                  ld;
	logic [VAL_W-1:0]      ld_rv;
	logic                  ld_upd;
	logic                  ld_done;

	assign acc      = req.valid && req.ready;
	assign in_range = 32'(req.entry_index) < 32'(PALETTE_ENTRIES);
	assign idx_a    = ADDR_W'(req.entry_index);
	assign val_c    = COLOR_BITS'(req.entry_value);
	assign cnt_a    = cnt_q[ADDR_W-1:0];
	assign reading  = cnt_q < CNT_END;
	assign tick_inc = tick_q + 1'b1;

	assign req.ready = (state_q == ST_IDLE) && (!rsp_v_q || rsp.ready);

	// read-modify-write of one entry, data from the previous cycle's read
	always_comb begin
		if (cfg.fade_in_mode) begin
			entry_chg = cur_rdata < tgt_rdata;
			entry_new = cur_rdata + 1'b1;
		end else begin
			entry_chg = cur_rdata != '0;
			entry_new = cur_rdata - 1'b1;
		end
	end

	// memory ports
	always_comb begin
		cur_we    = 1'b0;
		cur_waddr = idx_a;
		cur_wdata = val_c;
		cur_raddr = idx_a;
		unique case (state_q)
			ST_IDLE: cur_we = acc && (req.kind == KIND_WR_CUR) && in_range;
			ST_READ: ;
			ST_CLEAR: begin
				cur_we    = 1'b1;
				cur_waddr = cnt_a;
				cur_wdata = '0;
			end
			ST_SWEEP: begin
				cur_we    = valid_s1 && entry_chg;
				cur_waddr = addr_s1;
				cur_wdata = entry_new;
				cur_raddr = cnt_a;
			end
		endcase
	end

	assign tgt_we    = (state_q == ST_IDLE) && acc && (req.kind == KIND_WR_TGT) && in_range;
	assign tgt_waddr = idx_a;
	assign tgt_wdata = val_c;
	assign tgt_raddr = cnt_a;

	// control
	always_comb begin
		state_d   = state_q;
		done_d    = done_q;
		tick_d    = tick_q;
		cnt_d     = cnt_q;
		changed_d = changed_q;
		ld        = 1'b0;
		ld_rv     = '0;
		ld_upd    = 1'b0;
		ld_done   = done_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (req.kind)
						KIND_TICK: begin
							if (done_q) begin
								ld = 1'b1;
							end else begin
								tick_d = (tick_inc >= cfg.interval) ? '0 : tick_inc;
								if (tick_q == '0) begin
									state_d   = ST_SWEEP;
									cnt_d     = '0;
									changed_d = 1'b0;
								end else begin
									ld = 1'b1;
								end
							end
						end
						KIND_RD_CUR: state_d = ST_READ;
						KIND_START: begin
							tick_d  = '0;
							done_d  = 1'b0;
							ld_done = 1'b0;
							if (cfg.fade_in_mode) begin
								state_d = ST_CLEAR;
								cnt_d   = '0;
							end else begin
								ld = 1'b1;
							end
						end
						default: ld = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				ld      = 1'b1;
				ld_rv   = range_q ? VAL_W'(cur_rdata) : '0;
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					ld      = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (reading) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (valid_s1 && entry_chg) begin
					changed_d = 1'b1;
				end
				if (!reading && !valid_s1) begin
					ld      = 1'b1;
					ld_upd  = cfg.fade_in_mode || changed_q;
					ld_done = !changed_q;
					done_d  = !changed_q;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rsp_v_q   <= 1'b0;
			done_q    <= 1'b1;
			tick_q    <= '0;
			cnt_q     <= '0;
			valid_s1  <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= done_d;
			tick_q    <= tick_d;
			cnt_q     <= cnt_d;
			changed_q <= changed_d;
			valid_s1  <= (state_q == ST_SWEEP) && reading;
			if (ld) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_a;
		if (acc) begin
			range_q <= in_range;
		end
		if (ld) begin
			rv_q       <= ld_rv;
			upd_q      <= ld_upd;
			done_out_q <= ld_done;
		end
	end

	assign rsp.valid           = rsp_v_q;
	assign rsp.read_value      = rv_q;
	assign rsp.palette_updated = upd_q;
	assign rsp.fade_done       = done_out_q;

	`PFE_ASSERT_NOW(a_no_rmw_clash, (state_q == ST_SWEEP) && cur_we && reading,
		cur_waddr != cur_raddr, "sweep write hits entry being read")
	`PFE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_END, "entry counter past palette end")
	`PFE_ASSERT_NOW(a_done_from_sweep, $rose(done_q), $past(state_q == ST_SWEEP),
		"done set outside a sweep")
	`PFE_ASSERT_NEXT(a_write_immediate,
		acc && (req.kind == KIND_WR_CUR || req.kind == KIND_WR_TGT),
		(state_q == ST_IDLE) && rsp_v_q, "entry write did not answer at once")
endmodule

`default_nettype wire

/* test/pfe_fade_checker.sv */
`timescale 1ns / 1ps

module pfe_fade_checker
	import pfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	pfe_in_if                 req,
	pfe_out_if                rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int unsigned       mismatches,
	output int unsigned       results_seen,
	output int unsigned       pending,
	output int unsigned       sweeps,
	output int unsigned       fades_done
);

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             palette_updated;
		logic             fade_done;
	} fade_result_t;

	// shadow of the block: palettes, phase, done flag and registers
	logic [VAL_W-1:0]  cur_pal [PALETTE_ENTRIES_DEF];
	logic [VAL_W-1:0]  tgt_pal [PALETTE_ENTRIES_DEF];
	logic [TICK_W-1:0] tick_phase;
	logic              fade_idle;
	logic              fade_in;
	logic [STEP_W-1:0] fade_step;

	fade_result_t fade_result_q[$];
	int unsigned  miss_cnt, seen_cnt, sweep_cnt, done_cnt;

	function automatic int unsigned sweep_interval(input logic [STEP_W-1:0] s);
		if (s >= STEP_W'(STEP_DIV))
			return (int'(s) / STEP_DIV) * SLOW_UNIT;
		if (s == '0)
			return 1;
		return int'(s);
	endfunction

	// one pass over the palette, true when anything moved
	function automatic bit sweep_palette();
		bit changed = 1'b0;
		for (int i = 0; i < PALETTE_ENTRIES_DEF; i++) begin
			if (fade_in) begin
				if (cur_pal[i] < tgt_pal[i]) begin
					cur_pal[i] = cur_pal[i] + 1'b1;
					changed = 1'b1;
				end
			end else if (cur_pal[i] != '0) begin
				cur_pal[i] = cur_pal[i] - 1'b1;
				changed = 1'b1;
			end
		end
		return changed;
	endfunction

	function automatic fade_result_t predict_item(input logic [KIND_W-1:0] kind,
			input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		fade_result_t r;
		bit in_range;
		bit changed;
		int unsigned span;
		r = '0;
		in_range = idx < PALETTE_ENTRIES_DEF;
		case (kind)
			KIND_WR_CUR: begin
				if (in_range)
					cur_pal[idx] = val;
			end
			KIND_WR_TGT: begin
				if (in_range)
					tgt_pal[idx] = val;
			end
			KIND_TICK: begin
				if (!fade_idle) begin
					span = sweep_interval(fade_step);
					if (tick_phase == '0) begin
						changed = sweep_palette();
						sweep_cnt++;
						r.palette_updated = fade_in || changed;
						if (!changed) begin
							fade_idle = 1'b1;
							done_cnt++;
						end
					end
					tick_phase = tick_phase + 1'b1;
					if (tick_phase >= span)
						tick_phase = '0;
				end
			end
			KIND_RD_CUR: begin
				if (in_range)
					r.read_value = cur_pal[idx];
			end
			KIND_START: begin
				if (fade_in)
					foreach (cur_pal[i])
						cur_pal[i] = '0;
				tick_phase = '0;
				fade_idle = 1'b0;
			end
			default: ;
		endcase
		r.fade_done = fade_idle;
		return r;
	endfunction

	task automatic flag_mismatch(input string why, input fade_result_t want,
			input fade_result_t got);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("%0t %s: expected read=%0d upd=%0b done=%0b, got read=%0d upd=%0b done=%0b",
				$realtime, why, want.read_value, want.palette_updated, want.fade_done,
				got.read_value, got.palette_updated, got.fade_done);
	endtask

	always @(posedge clk or negedge arst_n) begin
		fade_result_t want;
		fade_result_t got;
		if (!arst_n) begin
			foreach (cur_pal[i]) begin
				cur_pal[i] = '0;
				tgt_pal[i] = '0;
			end
			tick_phase = '0;
			fade_idle = 1'b1;
			fade_in = 1'b0;
			fade_step = STEP_RST;
			fade_result_q.delete();
			miss_cnt = 0;
			seen_cnt = 0;
			sweep_cnt = 0;
			done_cnt = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_MODE: fade_in = pwdata[0];
					REG_STEP: fade_step = pwdata[STEP_W-1:0];
					default: ;
				endcase
			end
			// pop before push: a new transaction may be taken on the same edge
			if (rsp.valid && rsp.ready) begin
				seen_cnt++;
				got = '{rsp.read_value, rsp.palette_updated, rsp.fade_done};
				if (fade_result_q.size() == 0) begin
					flag_mismatch("unexpected result", '0, got);
				end else begin
					want = fade_result_q.pop_front();
					if (got !== want)
						flag_mismatch("result mismatch", want, got);
				end
			end
			if (req.valid && req.ready)
				fade_result_q.push_back(predict_item(req.kind, req.entry_index, req.entry_value));
		end
		mismatches <= miss_cnt;
		results_seen <= seen_cnt;
		pending <= fade_result_q.size();
		sweeps <= sweep_cnt;
		fades_done <= done_cnt;
	end

endmodule

/* test/palette_fade_engine_top_test.sv */
`timescale 1ns / 1ps

module palette_fade_engine_top_test;
	import pfe_pkg::*;

	// random part length, counted on items the block acts on
	localparam int unsigned RANDOM_ITEMS = 780;
	// worst case is ~2.5k transactions each paying a full sweep plus the
	// longest gap and stalls; this is several times that
	localparam int unsigned CYCLE_LIMIT  = 30_000_000;
	// after the last result, allow one sweep worth of cycles to settle
	localparam int unsigned DRAIN_CYCLES = PALETTE_ENTRIES_DEF + 8;
	// kinds the block does not decode
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam logic [IDX_W-1:0]  IDX_TOP = '1;
	localparam logic [VAL_W-1:0]  VAL_TOP = '1;
	// most entry values stay at or below this so fades finish in a few sweeps
	localparam int unsigned       VAL_LOW = 3;

	typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_pattern_e;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	pfe_in_if  req_if();
	pfe_out_if rsp_if();

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned pending;
	int unsigned sweeps;
	int unsigned fades_done;

	int unsigned cycles = 0;
	int unsigned items_sent;
	int unsigned useful_items;
	int unsigned reg_writes;
	int unsigned burst_left;

	// in-range indexes currently holding a large value; flattened before
	// most fades so that the fade can actually reach done
	logic [IDX_W-1:0] tall_cur[$];
	logic [IDX_W-1:0] tall_tgt[$];

	rx_pattern_e rx_pattern;
	int unsigned rx_left;
	int unsigned rx_phase;

	palette_fade_engine_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pfe_fade_checker fade_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_if),
		.rsp          (rsp_if),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.pending      (pending),
		.sweeps       (sweeps),
		.fades_done   (fades_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d of %0d results in", results_seen, items_sent);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side back-pressure. The pattern switches at random between always
	// ready, ready three times in four and a fixed periodic
	// rhythm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rx_pattern <= RX_OPEN;
			rx_left <= 0;
			rx_phase <= 0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (rx_left == 0) begin
				rx_pattern <= rx_pattern_e'($urandom_range(0, 2));
				rx_left <= $urandom_range(16, 256);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_pattern)
				RX_OPEN:   rsp_if.ready <= 1'b1;
				RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
				default:   rsp_if.ready <= (rx_phase % 5) > 1;
			endcase
		end
	end

	function automatic logic [IDX_W-1:0] pick_index();
		// one in eight lands above the palette, where writes are dropped
		if ($urandom_range(0, 7) == 0)
			return IDX_W'($urandom_range(PALETTE_ENTRIES_DEF, IDX_TOP));
		return IDX_W'($urandom_range(0, PALETTE_ENTRIES_DEF - 1));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 11) == 0)
			return VAL_W'($urandom_range(0, VAL_TOP));
		return VAL_W'($urandom_range(0, VAL_LOW));
	endfunction

	// One request transaction. Bursts of back-to-back transactions are
	// separated by idle gaps; valid drops only at a burst end (or in
	// settle), so it never takes two updates in one time step.
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			// mostly short gaps, now and then one as long as a sweep
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(13, PALETTE_ENTRIES_DEF + 8)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.kind <= kind;
		req_if.entry_index <= idx;
		req_if.entry_value <= val;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
		if (kind <= KIND_START && (idx < PALETTE_ENTRIES_DEF || kind == KIND_TICK
				|| kind == KIND_START))
			useful_items++;
		if (burst_left == 0)
			req_if.valid <= 1'b0;
	endtask

	// random entry write, remembering where large values went
	task automatic write_entry(input logic [KIND_W-1:0] kind);
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		idx = pick_index();
		val = pick_value();
		send_item(kind, idx, val);
		if (val > VAL_LOW && idx < PALETTE_ENTRIES_DEF) begin
			if (kind == KIND_WR_TGT)
				tall_tgt.push_back(idx);
			else
				tall_cur.push_back(idx);
		end
	endtask

	// close the current burst and wait until every result is back
	task automatic settle();
		if (burst_left != 0) begin
			req_if.valid <= 1'b0;
			burst_left = 0;
		end
		while (results_seen < items_sent)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_reg(input logic reg_idx, input logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({reg_idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
	endtask

	// registers change only with nothing in flight
	task automatic configure(input logic mode, input logic [STEP_W-1:0] step);
		settle();
		write_reg(REG_MODE, APB_DW'(mode));
		write_reg(REG_STEP, APB_DW'(step));
	endtask

	initial begin
		logic              mode_sel;
		logic [STEP_W-1:0] step_sel;
		int unsigned       random_base;

		// every block input known from time zero
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.kind <= KIND_WR_CUR;
		req_if.entry_index <= '0;
		req_if.entry_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		items_sent = 0;
		useful_items = 0;
		reg_writes = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The palette RAMs come up undefined, so load every current and
		// target entry before anything reads or fades them.
		for (int i = 0; i < PALETTE_ENTRIES_DEF; i++) begin
			send_item(KIND_WR_CUR, IDX_W'(i), VAL_W'($urandom_range(0, VAL_LOW)));
			send_item(KIND_WR_TGT, IDX_W'(i), VAL_W'($urandom_range(0, VAL_LOW)));
		end

		// ---- directed: reset settings (fade-out, step 4 -> interval 10000) ----
		send_item(KIND_RD_CUR, '0, '0);
		send_item(KIND_WR_CUR, '0, VAL_TOP);
		send_item(KIND_RD_CUR, '0, '0);
		// index above the palette: write dropped, read gives zero
		send_item(KIND_WR_CUR, IDX_TOP, VAL_TOP);
		send_item(KIND_RD_CUR, IDX_TOP, VAL_TOP);
		send_item(KIND_WR_TGT, IDX_TOP, VAL_TOP);
		send_item(KIND_WR_TGT, IDX_W'(PALETTE_ENTRIES_DEF - 1), '0);
		send_item(KIND_WR_CUR, IDX_W'(PALETTE_ENTRIES_DEF - 1), '0);
		send_item(KIND_RD_CUR, IDX_W'(PALETTE_ENTRIES_DEF - 1), '0);
		// undecoded kinds
		send_item(KIND_SPARE_LO, IDX_TOP, VAL_TOP);
		send_item(KIND_W'(KIND_SPARE_LO + 1), '0, '0);
		send_item(KIND_SPARE_HI, IDX_W'($urandom), VAL_W'($urandom));
		// done is set out of reset, so this tick does nothing
		send_item(KIND_TICK, '0, '0);
		send_item(KIND_WR_CUR, '0, VAL_W'(VAL_LOW));
		send_item(KIND_START, '0, '0);
		// first tick after start sweeps, the next one is inside the interval
		send_item(KIND_TICK, '0, '0);
		send_item(KIND_TICK, IDX_TOP, VAL_TOP);
		send_item(KIND_RD_CUR, '0, '0);

		// ---- directed: fade-out every tick, run to done and past it ----
		// everything is below VAL_LOW after the earlier sweep, so the changing
		// sweeps end before the VAL_LOW-th and a later one finds nothing and reports no update
		configure(1'b0, STEP_W'(1));
		send_item(KIND_START, '0, '0);
		repeat (VAL_LOW + 2) send_item(KIND_TICK, '0, '0);

		// ---- random sessions ----
		// Mostly well-formed: settings, a few entry writes, start, then ticks
		// mixed with reads, writes and undecoded kinds. Some sessions skip the
		// start, so a fade carries on under changed mode or step.
		random_base = useful_items;
		while (useful_items - random_base < RANDOM_ITEMS) begin
			mode_sel = $urandom_range(0, 1);
			case ($urandom_range(0, 9))
				6:       step_sel = '0;
				7:       step_sel = STEP_W'($urandom_range(4, 7));
				8:       step_sel = '1;
				9:       step_sel = STEP_W'($urandom);
				default: step_sel = STEP_W'($urandom_range(1, 3));
			endcase
			configure(mode_sel, step_sel);

			if ($urandom_range(0, 3) != 0) begin
				if (mode_sel) begin
					foreach (tall_tgt[i])
						send_item(KIND_WR_TGT, tall_tgt[i], VAL_W'($urandom_range(0, VAL_LOW)));
					tall_tgt.delete();
				end else begin
					foreach (tall_cur[i])
						send_item(KIND_WR_CUR, tall_cur[i], VAL_W'($urandom_range(0, VAL_LOW)));
					tall_cur.delete();
				end
			end

			repeat ($urandom_range(0, 6))
				write_entry($urandom_range(0, 1) ? KIND_WR_TGT : KIND_WR_CUR);
			if ($urandom_range(0, 9) != 0)
				send_item(KIND_START, IDX_W'($urandom), VAL_W'($urandom));

			repeat ($urandom_range(4, 30)) begin
				case ($urandom_range(0, 9))
					0: send_item(KIND_RD_CUR, pick_index(), VAL_W'($urandom));
					1: write_entry($urandom_range(0, 1) ? KIND_WR_TGT : KIND_WR_CUR);
					2: send_item(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
						IDX_W'($urandom), VAL_W'($urandom));
					default: send_item(KIND_TICK, IDX_W'($urandom), VAL_W'($urandom));
				endcase
			end
		end

		// drain, then give the block time to show any stray result
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d transactions and %0d register writes: %0d sweeps, %0d fades to done",
			items_sent, reg_writes, sweeps, fades_done);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
